// ===== rtl/core/bshvf_pkg.sv =====
// Shared types and constants for the bitstate hash visited filter.
// No dependencies.
package bshvf_pkg;
    localparam int unsigned TableDepth = 1048576;
    localparam int unsigned SlotW      = 20;
    localparam int unsigned HashW      = 56;
    localparam int unsigned SizeW      = 21;
    localparam int unsigned BmWordsLog = 15;
    localparam int unsigned QDepthLog  = 2;
    localparam logic [31:0] SeedA   = 32'h9e3779b9;
    localparam logic [31:0] SeedB   = 32'h65e3083a;
    localparam logic [31:0] SeedC   = 32'h a45f7582;
    localparam logic [31:0] PadWord = 32'h76a34e87;

    // one finished hash handed from front to back
    typedef struct packed {
        logic [HashW-1:0] hash;
    } t_hash_item;
endpackage

// ===== rtl/core/bshvf_front.sv =====
// Front end: absorbs words into the accumulators, runs the mix, pads and folds.
// Depends on bshvf_pkg.
module bshvf_front (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic [31:0]             i_word,
    input  logic                    i_last_word,
    output logic                    o_hvalid,
    input  logic                    i_hready,
    output bshvf_pkg::t_hash_item   o_hitem
);
    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_MIX1 = 4'b0010,
        S_MIX2 = 4'b0100,
        S_OUT  = 4'b1000
    } t_state;

    t_state      r_state, n_state;
    logic [31:0] r_a, r_b, r_c, n_a, n_b, n_c;
    logic [1:0]  r_phase, n_phase;
    logic        r_last, n_last;
    logic [bshvf_pkg::HashW-1:0] r_hash, n_hash;

    logic [31:0] m_a, m_b, m_c, s_a, s_b, s_c;
    logic [31:0] w_src;

    assign o_ready  = (r_state == S_IDLE);
    assign o_hvalid = (r_state == S_OUT);
    assign o_hitem.hash = r_hash;

    // first half of the mix: five of nine rounds
    always_comb begin
        m_a = r_a; m_b = r_b; m_c = r_c;
        m_a = m_a - m_b - m_c; m_a = m_a ^ (m_c >> 13);
        m_b = m_b - m_c - m_a; m_b = m_b ^ (m_a << 8);
        m_c = m_c - m_a - m_b; m_c = m_c ^ (m_b >> 13);
        m_a = m_a - m_b - m_c; m_a = m_a ^ (m_c >> 12);
        m_b = m_b - m_c - m_a; m_b = m_b ^ (m_a << 16);
    end
    // second half
    always_comb begin
        s_a = r_a; s_b = r_b; s_c = r_c;
        s_c = s_c - s_a - s_b; s_c = s_c ^ (s_b >> 5);
        s_a = s_a - s_b - s_c; s_a = s_a ^ (s_c >> 3);
        s_b = s_b - s_c - s_a; s_b = s_b ^ (s_a << 10);
        s_c = s_c - s_a - s_b; s_c = s_c ^ (s_b >> 15);
    end

    // sequence absorb, mix, pad and fold
    always_comb begin
        n_state = r_state; n_a = r_a; n_b = r_b; n_c = r_c;
        n_phase = r_phase; n_last = r_last; n_hash = r_hash;
        w_src   = i_word;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_last = i_last_word;
                    case (r_phase)
                        2'd0: n_a = r_a + w_src;
                        2'd1: n_b = r_b + w_src;
                        default: n_c = r_c + w_src;
                    endcase
                    if (r_phase == 2'd2) begin
                        n_phase = 2'd0;
                        n_state = S_MIX1;
                    end else if (i_last_word) begin
                        // pad the remaining words of this group
                        n_phase = 2'd0;
                        if (r_phase == 2'd0) n_b = r_b + bshvf_pkg::PadWord;
                        n_c = r_c + bshvf_pkg::PadWord;
                        n_state = S_MIX1;
                    end else begin
                        n_phase = r_phase + 2'd1;
                    end
                end
            end
            S_MIX1: begin
                n_a = m_a; n_b = m_b; n_c = m_c;
                n_state = S_MIX2;
            end
            S_MIX2: begin
                n_a = s_a; n_b = s_b; n_c = s_c;
                if (r_last) begin
                    // fold: a high half at 55:40, b high half ORed in at 47:32
                    n_hash = {s_a[31:24], s_a[23:16] | s_b[31:24], s_b[23:16],
                              s_c[31:16], s_a[15:0] ^ s_b[15:0] ^ s_c[15:0]};
                    n_state = S_OUT;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_OUT: begin
                if (i_hready) begin
                    n_a = bshvf_pkg::SeedA; n_b = bshvf_pkg::SeedB;
                    n_c = bshvf_pkg::SeedC; n_last = 1'b0;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_a <= bshvf_pkg::SeedA; r_b <= bshvf_pkg::SeedB; r_c <= bshvf_pkg::SeedC;
            r_phase <= 2'd0; r_last <= 1'b0;
        end else begin
            r_state <= n_state;
            r_a <= n_a; r_b <= n_b; r_c <= n_c;
            r_phase <= n_phase; r_last <= n_last;
        end
        r_hash <= n_hash;
    end
endmodule

// ===== rtl/core/bshvf_queue.sv =====
// Short queue of finished hashes between front and back.
// Depends on bshvf_pkg.
module bshvf_queue (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  bshvf_pkg::t_hash_item i_item,
    output logic                  o_valid,
    input  logic                  i_ready,
    output bshvf_pkg::t_hash_item o_item
);
    localparam int unsigned L = bshvf_pkg::QDepthLog;
    bshvf_pkg::t_hash_item r_mem [2**L];
    logic [L-1:0] r_wp, r_rp;
    logic [L:0]   r_cnt;
    logic         push, pop;

    assign o_ready = (r_cnt != (L+1)'(2**L));
    assign o_valid = (r_cnt != '0);
    assign o_item  = r_mem[r_rp];
    assign push = i_valid && o_ready;
    assign pop  = o_valid && i_ready;

    // advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_cnt <= '0;
        end else begin
            if (push) r_wp <= r_wp + 1'b1;
            if (pop)  r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (L+1)'(push) - (L+1)'(pop);
        end
        if (push) r_mem[r_wp] <= i_item;
    end
endmodule

// ===== rtl/core/bshvf_back.sv =====
// Back end: reduces the hash modulo the table size bit-serially, then
// tests and sets the bitmap bit. Depends on bshvf_pkg.
module bshvf_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [bshvf_pkg::SizeW-1:0]   i_size,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  bshvf_pkg::t_hash_item         i_item,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic                          o_is_new,
    output logic [bshvf_pkg::SlotW-1:0]   o_slot,
    output logic [bshvf_pkg::HashW-1:0]   o_full_hash
);
    localparam int unsigned HW = bshvf_pkg::HashW;
    localparam int unsigned SW = bshvf_pkg::SizeW;
    localparam int unsigned WL = bshvf_pkg::BmWordsLog;

    typedef enum logic [5:0] {
        S_CLR  = 6'b000001,
        S_IDLE = 6'b000010,
        S_DIV  = 6'b000100,
        S_RD   = 6'b001000,
        S_WR   = 6'b010000,
        S_OUT  = 6'b100000
    } t_state;

    t_state          r_state;
    logic [HW-1:0]   r_hash;
    logic [SW-1:0]   r_size, r_rem;
    logic [5:0]      r_cnt;
    logic [WL-1:0]   r_clr;
    logic [31:0]     r_mem [2**WL];
    logic [31:0]     r_rdata;
    logic            r_new;
    logic [SW:0]     trial;
    logic [SW-1:0]   eff;
    logic [SW-2:0]   slot_f;

    // clamp size to the valid range
    always_comb begin
        eff = i_size;
        if (i_size == '0) eff = SW'(1);
        if (i_size > SW'(bshvf_pkg::TableDepth)) eff = SW'(bshvf_pkg::TableDepth);
    end

    assign trial  = {r_rem, r_hash[HW-1]};
    assign slot_f = r_rem[SW-2:0];
    assign o_ready     = (r_state == S_IDLE);
    assign o_valid     = (r_state == S_OUT);
    assign o_is_new    = r_new;
    assign o_slot      = slot_f;
    assign o_full_hash = r_hash;

    // clear sweep, restoring division, read then write of the bitmap word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_clr   <= '0;
        end else begin
            case (r_state)
                S_CLR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == '1) r_state <= S_IDLE;
                end
                S_IDLE: if (i_valid) r_state <= S_DIV;
                S_DIV:  if (r_cnt == 6'(HW - 1)) r_state <= S_RD;
                S_RD:   r_state <= S_WR;
                S_WR:   r_state <= S_OUT;
                S_OUT:  if (i_ready) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
        case (r_state)
            S_IDLE: begin
                r_hash <= i_item.hash; r_size <= eff;
                r_rem <= '0; r_cnt <= '0;
            end
            S_DIV: begin
                // one quotient bit a cycle; the hash rotates back to itself
                r_hash <= {r_hash[HW-2:0], r_hash[HW-1]};
                r_cnt  <= r_cnt + 6'd1;
                if (trial >= {1'b0, r_size}) r_rem <= SW'(trial - {1'b0, r_size});
                else r_rem <= trial[SW-1:0];
            end
            default: ;
        endcase
        if (r_state == S_CLR) r_mem[r_clr] <= '0;
        else if (r_state == S_WR) r_mem[slot_f[SW-2:5]] <= r_rdata | (32'd1 << slot_f[4:0]);
        r_rdata <= r_mem[slot_f[SW-2:5]];
        if (r_state == S_WR) r_new <= !r_rdata[slot_f[4:0]];
    end
endmodule

// ===== rtl/core/bitstate_hash_visited_filter.sv =====
// Bitstate visited filter: hashes state vectors and tests-and-sets a bitmap.
// The front end holds o_ready low while it mixes a group of three words; the bitmap
// stage reduces the hash bit-serially, then reads and writes the bitmap word.
// The back end takes a new state only once it is done with the last one.
// Reset: synchronous active low; the bitmap is cleared by a sweep after reset,
// during which results wait in the queue. Depends on bshvf_pkg and the front, queue and back modules.
module bitstate_hash_visited_filter (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [31:0] i_word,
    input  logic        i_last_word,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_is_new,
    output logic [19:0] o_slot,
    output logic [55:0] o_full_hash,
    input  logic        i_cfg_we,
    input  logic [20:0] i_cfg_data
);
    logic [20:0] r_size;
    logic f_v, f_r, q_v, q_r;
    bshvf_pkg::t_hash_item f_item, q_item;

    // hold the table size register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_size <= 21'(bshvf_pkg::TableDepth);
        else if (i_cfg_we) r_size <= i_cfg_data;
    end

    bshvf_front u_front (.i_clk, .i_rst_n, .i_valid, .o_ready, .i_word, .i_last_word,
        .o_hvalid(f_v), .i_hready(f_r), .o_hitem(f_item));
    bshvf_queue u_queue (.i_clk, .i_rst_n, .i_valid(f_v), .o_ready(f_r), .i_item(f_item),
        .o_valid(q_v), .i_ready(q_r), .o_item(q_item));
    bshvf_back u_back (.i_clk, .i_rst_n, .i_size(r_size), .i_valid(q_v), .o_ready(q_r),
        .i_item(q_item), .o_valid, .i_ready, .o_is_new, .o_slot, .o_full_hash);
endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// Testbench for bitstate_hash_visited_filter: streams state-vector words in and
// checks each new-state flag, slot and folded hash against a built-in predictor.
// Depends on bshvf_pkg and the filter RTL.
module testbench;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [31:0] i_word = '0;
    logic        i_last_word = 1'b0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic        o_is_new;
    logic [19:0] o_slot;
    logic [55:0] o_full_hash;
    logic        i_cfg_we = 1'b0;
    logic [20:0] i_cfg_data = '0;

    typedef struct packed {
        logic                        is_new;
        logic [bshvf_pkg::SlotW-1:0] slot;
        logic [bshvf_pkg::HashW-1:0] full_hash;
    } t_lookup;

    // predictor state
    bit [31:0]                  acc_a, acc_b, acc_c;
    int unsigned                word_phase;
    bit                         visited_map [bshvf_pkg::TableDepth];
    bit [bshvf_pkg::SizeW-1:0]  table_size;
    t_lookup                    pending_lookups [$];
    int                         error_count = 0;
    int                         words_sent = 0;
    bit                         idle_on = 1'b1;

    bitstate_hash_visited_filter DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready),
        .i_word(i_word), .i_last_word(i_last_word),
        .o_valid(o_valid), .i_ready(i_ready),
        .o_is_new(o_is_new), .o_slot(o_slot), .o_full_hash(o_full_hash),
        .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // hard stop if the block hangs
    initial begin
        #5ms;
        $display("Test completed with failures");
        $finish;
    end

    function automatic void restart_hash();
        acc_a = bshvf_pkg::SeedA;
        acc_b = bshvf_pkg::SeedB;
        acc_c = bshvf_pkg::SeedC;
        word_phase = 0;
    endfunction

    function automatic void mix_accumulators();
        bit [31:0] a, b, c;
        a = acc_a; b = acc_b; c = acc_c;
        a -= b; a -= c; a ^= (c >> 13);
        b -= c; b -= a; b ^= (a << 8);
        c -= a; c -= b; c ^= (b >> 13);
        a -= b; a -= c; a ^= (c >> 12);
        b -= c; b -= a; b ^= (a << 16);
        c -= a; c -= b; c ^= (b >> 5);
        a -= b; a -= c; a ^= (c >> 3);
        b -= c; b -= a; b ^= (a << 10);
        c -= a; c -= b; c ^= (b >> 15);
        acc_a = a; acc_b = b; acc_c = c;
    endfunction

    function automatic void absorb_word(bit [31:0] w);
        case (word_phase)
            0: begin
                acc_a += w;
                word_phase = 1;
            end
            1: begin
                acc_b += w;
                word_phase = 2;
            end
            default: begin
                acc_c += w;
                word_phase = 0;
                mix_accumulators();
            end
        endcase
    endfunction

    // advance the predictor by one accepted word; queue a lookup on the last one
    function automatic void predict_lookup(bit [31:0] w, bit last);
        bit [63:0] h, size, slot;
        t_lookup   exp_lookup;
        absorb_word(w);
        if (!last) return;
        while (word_phase != 0) absorb_word(bshvf_pkg::PadWord);
        h = {32'b0, acc_a & 32'hffff0000} << 24;
        h |= {32'b0, acc_b & 32'hffff0000} << 16;
        h |= {32'b0, acc_c & 32'hffff0000};
        h |= {48'b0, acc_a[15:0] ^ acc_b[15:0] ^ acc_c[15:0]};
        h &= 64'h00ff_ffff_ffff_ffff;
        size = 64'(table_size);
        if (size == 0) size = 64'd1;
        if (size > 64'(bshvf_pkg::TableDepth)) size = 64'(bshvf_pkg::TableDepth);
        slot = h % size;
        exp_lookup.is_new = !visited_map[slot[bshvf_pkg::SlotW-1:0]];
        visited_map[slot[bshvf_pkg::SlotW-1:0]] = 1'b1;
        exp_lookup.slot = slot[bshvf_pkg::SlotW-1:0];
        exp_lookup.full_hash = h[bshvf_pkg::HashW-1:0];
        pending_lookups.push_back(exp_lookup);
        restart_hash();
    endfunction

    // receiver stalls in random bursts while idle_on is set
    initial begin
        int stall;
        forever begin
            @(negedge i_clk);
            if (idle_on && $urandom_range(0, 3) == 0) begin
                stall = $urandom_range(1, 19);
                i_ready <= 1'b0;
                repeat (stall - 1) @(negedge i_clk);
            end else begin
                i_ready <= 1'b1;
                if ($urandom_range(0, 1) == 0) repeat ($urandom_range(1, 30)) @(negedge i_clk);
            end
        end
    end

    // compare every accepted result word with the oldest expectation
    always @(posedge i_clk) begin
        t_lookup exp_lookup;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_lookups.size() == 0) begin
                $error("unexpected result: slot %0d hash %h", o_slot, o_full_hash);
                error_count++;
            end else begin
                exp_lookup = pending_lookups.pop_front();
                if (o_is_new !== exp_lookup.is_new) begin
                    $error("is_new: expected %0d actual %0d", exp_lookup.is_new, o_is_new);
                    error_count++;
                end
                if (o_slot !== exp_lookup.slot) begin
                    $error("slot: expected %0d actual %0d", exp_lookup.slot, o_slot);
                    error_count++;
                end
                if (o_full_hash !== exp_lookup.full_hash) begin
                    $error("full_hash: expected %h actual %h",
                           exp_lookup.full_hash, o_full_hash);
                    error_count++;
                end
            end
        end
    end

    // send one word; valid is left high so back-to-back words need no gap
    task automatic send_word(bit [31:0] w, bit last);
        if (idle_on && $urandom_range(0, 4) == 0) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 19) - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_valid <= 1'b1;
        i_word <= w;
        i_last_word <= last;
        do @(posedge i_clk); while (!o_ready);
        predict_lookup(w, last);
        words_sent++;
    endtask

    task automatic send_state(int unsigned len);
        for (int unsigned k = 0; k < len; k++)
            send_word($urandom(), k == len - 1);
    endtask

    // drop valid and wait until every lookup is back and the back end is done
    task automatic drain();
        int guard;
        @(negedge i_clk);
        i_valid <= 1'b0;
        guard = 0;
        while (pending_lookups.size() != 0 && guard < 200000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (80) @(posedge i_clk);
    endtask

    task automatic write_table_size(bit [bshvf_pkg::SizeW-1:0] size);
        drain();
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_data <= size;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        table_size = size;
    endtask

    // word extremes, state lengths around the mix boundary, repeated states
    task automatic test_word_extremes();
        send_word(32'h0, 1'b1);
        send_word(32'hffffffff, 1'b1);
        send_word(32'h0, 1'b1);
        send_word(32'hffffffff, 1'b0);
        send_word(32'h0, 1'b1);
        send_word(32'haaaaaaaa, 1'b0);
        send_word(32'h55555555, 1'b0);
        send_word(32'hffffffff, 1'b1);
        for (int k = 0; k < 4; k++) send_word(32'(32'h12345678 + k), k == 3);
        for (int k = 0; k < 6; k++) send_word(32'hffffffff, k == 5);
        for (int k = 0; k < 6; k++) send_word(32'hffffffff, k == 5);
    endtask

    // table size extremes: zero, one, below and above the table depth
    task automatic test_table_sizes();
        bit [bshvf_pkg::SizeW-1:0] sizes [8] = '{21'd0, 21'd1, 21'd2, 21'd7, 21'd64,
                                                 21'd1048575, 21'd1048577, 21'h1fffff};
        foreach (sizes[s]) begin
            write_table_size(sizes[s]);
            repeat (4) send_state($urandom_range(1, 4));
        end
    endtask

    // random states, with random size changes between states; last part without idling
    task automatic test_random_states(int unsigned word_goal);
        bit [bshvf_pkg::SizeW-1:0] size_pick;
        int unsigned               start = words_sent;
        while (words_sent - start < word_goal) begin
            if ($urandom_range(0, 39) == 0) begin
                case ($urandom_range(0, 3))
                    0: size_pick = bshvf_pkg::SizeW'($urandom_range(1, 16));
                    1: size_pick = bshvf_pkg::SizeW'($urandom_range(17, 5000));
                    2: size_pick = bshvf_pkg::SizeW'(bshvf_pkg::TableDepth);
                    default: size_pick = bshvf_pkg::SizeW'($urandom());
                endcase
                write_table_size(size_pick);
            end
            if (words_sent - start > word_goal * 5 / 6) idle_on = 1'b0;
            send_state($urandom_range(0, 3) == 0 ? $urandom_range(5, 10)
                                                 : $urandom_range(1, 4));
        end
    endtask

    initial begin
        restart_hash();
        table_size = bshvf_pkg::SizeW'(bshvf_pkg::TableDepth);
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_word_extremes();
        test_table_sizes();
        write_table_size(bshvf_pkg::SizeW'(bshvf_pkg::TableDepth));
        test_random_states(850);
        drain();

        if (error_count == 0 && pending_lookups.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule

// ===== bitstate_hash_visited_filter.f =====
rtl/core/bshvf_pkg.sv
rtl/core/bshvf_front.sv
rtl/core/bshvf_queue.sv
rtl/core/bshvf_back.sv
rtl/core/bitstate_hash_visited_filter.sv
tb/sv/testbench.sv
